// File: hw/rtl/mgbp_pkg.sv
// mgbp_pkg: shared types, constants and codes for the bilinear prolongation unit
// depends on nothing; imported by every module of the block

package mgbp_pkg;

  // fine grid size and derived widths
  localparam int FINE_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(FINE_DEPTH);
  // signed width of target address arithmetic (product, offsets, sign)
  localparam int CALC_W     = 28;
  localparam int DATA_W     = 32;

  // up to nine targets per coarse word
  localparam int TGT_MAX    = 9;
  localparam int TGT_IDX_W  = $clog2(TGT_MAX + 1);

  // configuration port
  localparam int PADDR_W    = 5;

  localparam logic [2:0] REG_ROW_WIDTH      = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT      = 3'd1;
  localparam logic [2:0] REG_COARSE_COLS    = 3'd2;
  localparam logic [2:0] REG_COARSE_ROWS    = 3'd3;
  localparam logic [2:0] REG_NEUMANN_COUNT  = 3'd4;
  localparam logic [2:0] REG_NEUMANN_OFFSET = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  typedef enum logic [1:0] {
    K_LOAD     = 2'd0,
    K_INTERIOR = 2'd1,
    K_NEUMANN  = 2'd2,
    K_READ     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    W_FULL  = 2'd0,
    W_HALF  = 2'd1,
    W_QUART = 2'd2
  } weight_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_RUN,
    ST_MEM,
    ST_RDCAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] row_width;
    logic [11:0] row_count;
    logic [10:0] coarse_cols;
    logic [10:0] coarse_rows;
    logic [10:0] neumann_count;
    logic [12:0] neumann_offset;
  } cfg_t;

  typedef struct packed {
    logic [CALC_W-1:0] addr;
    weight_t           w;
  } target_t;

  typedef struct packed {
    target_t [TGT_MAX-1:0] entry;
    logic [TGT_IDX_W-1:0]  cnt;
    logic                  err;
  } tgt_list_t;

endpackage

// File: hw/rtl/mgbp_grid_ram.sv
// mgbp_grid_ram: fine grid storage, one write port and one registered read port
// depends on mgbp_pkg for depth and widths

module mgbp_grid_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [mgbp_pkg::ADDR_W-1:0] waddr,
  input  logic [mgbp_pkg::DATA_W-1:0] wdata,
  input  logic [mgbp_pkg::ADDR_W-1:0] raddr,
  output logic [mgbp_pkg::DATA_W-1:0] rdata
);
  import mgbp_pkg::*;

  logic [DATA_W-1:0] mem [FINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mgbp_target_gen.sv
// mgbp_target_gen: two-stage target list builder for coarse words
// stage one multiplies the row stride, stage two forms addresses and checks range
// depends on mgbp_pkg

module mgbp_target_gen (
  input  logic               clk,
  input  mgbp_pkg::kind_t    kind,
  input  logic [10:0]        coarse_x,
  input  logic [10:0]        coarse_y,
  input  mgbp_pkg::cfg_t     cfg,
  output mgbp_pkg::tgt_list_t tgt
);
  import mgbp_pkg::*;

  logic [23:0] prod;
  logic [11:0] mul_a;
  tgt_list_t   tgt_next;

  assign mul_a = (kind == K_NEUMANN) ? cfg.row_count : {coarse_y, 1'b1};

  always_ff @(posedge clk) begin
    prod <= mul_a * cfg.row_width;
    tgt  <= tgt_next;
  end

  always_comb begin
    logic signed [CALC_W-1:0] nx;
    logic signed [CALC_W-1:0] off;
    logic signed [CALC_W-1:0] ind;
    logic signed [CALC_W-1:0] row;
    logic signed [CALC_W-1:0] b;
    logic signed [CALC_W-1:0] a;
    logic                     idx_err;
    logic                     rng_err;
    nx  = $signed(CALC_W'(cfg.row_width));
    off = $signed({{(CALC_W-13){cfg.neumann_offset[12]}}, cfg.neumann_offset});
    ind = '0;
    row = '0;
    b   = '0;
    a   = '0;
    tgt_next = '0;
    idx_err  = 1'b0;
    rng_err  = 1'b0;
    if (kind == K_NEUMANN) begin
      ind = $signed(CALC_W'(prod)) + $signed(CALC_W'({coarse_x, 1'b0}));
      b   = ind - nx + off;
      tgt_next.entry[0] = '{addr: b - 1, w: W_QUART};
      tgt_next.entry[1] = '{addr: b,     w: W_HALF};
      tgt_next.entry[2] = '{addr: b + 1, w: W_QUART};
      tgt_next.entry[3] = '{addr: ind,   w: W_FULL};
      if (coarse_x == 11'd0) begin
        tgt_next.entry[4] = '{addr: ind + 1, w: W_HALF};
        tgt_next.cnt      = TGT_IDX_W'(5);
      end else if (coarse_x == cfg.neumann_count - 11'd1) begin
        tgt_next.entry[4] = '{addr: ind - 1, w: W_HALF};
        tgt_next.cnt      = TGT_IDX_W'(5);
      end else begin
        tgt_next.entry[4] = '{addr: ind + 1, w: W_HALF};
        tgt_next.entry[5] = '{addr: ind - 1, w: W_HALF};
        tgt_next.cnt      = TGT_IDX_W'(6);
      end
      idx_err = (coarse_x >= cfg.neumann_count);
    end else begin
      ind = $signed(CALC_W'(prod)) + $signed(CALC_W'({coarse_x, 1'b1}));
      // rows above, center and below, each swept west to east
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          row = (dy == 0) ? ind - nx : ((dy == 1) ? ind : ind + nx);
          a   = row + CALC_W'(dx) - 1;
          tgt_next.entry[dy*3+dx].addr = a;
          if (dx == 1 && dy == 1) begin
            tgt_next.entry[dy*3+dx].w = W_FULL;
          end else if (dx == 1 || dy == 1) begin
            tgt_next.entry[dy*3+dx].w = W_HALF;
          end else begin
            tgt_next.entry[dy*3+dx].w = W_QUART;
          end
        end
      end
      tgt_next.cnt = TGT_IDX_W'(TGT_MAX);
      idx_err = (coarse_x >= cfg.coarse_cols) || (coarse_y >= cfg.coarse_rows);
    end
    for (int i = 0; i < TGT_MAX; i++) begin
      if (TGT_IDX_W'(i) < tgt_next.cnt) begin
        if ($signed(tgt_next.entry[i].addr) < 0 ||
            $signed(tgt_next.entry[i].addr) >= $signed(CALC_W'(FINE_DEPTH))) begin
          rng_err = 1'b1;
        end
      end
    end
    tgt_next.err = idx_err || rng_err;
  end

endmodule

// File: hw/rtl/multigrid_bilinear_prolongation_unit.sv
// multigrid_bilinear_prolongation_unit: top level, config registers, sequencer,
// saturating read-modify-write datapath; uses mgbp_pkg, mgbp_target_gen, mgbp_grid_ram
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  in       | in_valid / in_stall    | kind, fine_address, coarse_x, coarse_y, sample_value
//  out      | out_valid / out_stall  | read_value, status
//  cfg      | psel/penable/pwrite    | paddr, pwdata, prdata, pready (always high)
//
// the next word is taken once the result sits in the output register. an interior
// word issues one grid read per cycle for its nine targets, and each update write
// follows its read in the next cycle.
// rst is synchronous: control state and config registers take their reset values;
// the grid holds no reset value and must be loaded before use.
// out_stall only holds the result register; a finished word waits in ST_DONE until
// the output register is free, in_stall is high whenever the sequencer is busy.

module multigrid_bilinear_prolongation_unit (
  input  logic                         clk,
  input  logic                         rst,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind,
  input  logic [11:0]                  fine_address,
  input  logic [10:0]                  coarse_x,
  input  logic [10:0]                  coarse_y,
  input  logic signed [31:0]           sample_value,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           read_value,
  output logic [1:0]                   status,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mgbp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mgbp_pkg::*;

  state_t state, state_next;
  cfg_t   cfg;

  // held input word
  kind_t             kind_r;
  logic [11:0]       faddr_r;
  logic [10:0]       cx_r;
  logic [10:0]       cy_r;
  logic [DATA_W-1:0] sample_r;

  // target list from the address builder
  tgt_list_t tgt;

  // read-modify-write pipeline
  logic [TGT_IDX_W-1:0] rd_idx;
  logic [TGT_IDX_W-1:0] sel_idx;
  logic                 issue;
  logic                 pend;
  logic [ADDR_W-1:0]    pend_addr;
  weight_t              pend_w;
  logic                 fwd;
  logic [DATA_W-1:0]    fwd_data;
  logic                 sat_seen;
  logic [DATA_W-1:0]    res_value;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] addend;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] sum_sat;
  logic              sat_now;

  logic        accept;
  logic        faddr_err;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic [1:0]  res_status;
  logic [31:0] res_read;

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[4:2];

  // load and read address check against the grid depth
  assign faddr_err = CALC_W'(faddr_r) >= CALC_W'(FINE_DEPTH);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width      <= 12'd64;
      cfg.row_count      <= 12'd63;
      cfg.coarse_cols    <= 11'd31;
      cfg.coarse_rows    <= 11'd31;
      cfg.neumann_count  <= 11'd16;
      cfg.neumann_offset <= 13'd15;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_WIDTH:      cfg.row_width      <= pwdata[11:0];
        REG_ROW_COUNT:      cfg.row_count      <= pwdata[11:0];
        REG_COARSE_COLS:    cfg.coarse_cols    <= pwdata[10:0];
        REG_COARSE_ROWS:    cfg.coarse_rows    <= pwdata[10:0];
        REG_NEUMANN_COUNT:  cfg.neumann_count  <= pwdata[10:0];
        REG_NEUMANN_OFFSET: cfg.neumann_offset <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_WIDTH:      prdata = 32'(cfg.row_width);
      REG_ROW_COUNT:      prdata = 32'(cfg.row_count);
      REG_COARSE_COLS:    prdata = 32'(cfg.coarse_cols);
      REG_COARSE_ROWS:    prdata = 32'(cfg.coarse_rows);
      REG_NEUMANN_COUNT:  prdata = 32'(cfg.neumann_count);
      REG_NEUMANN_OFFSET: prdata = {{19{cfg.neumann_offset[12]}}, cfg.neumann_offset};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- units
  mgbp_target_gen u_tgen (
    .clk      (clk),
    .kind     (kind_r),
    .coarse_x (cx_r),
    .coarse_y (cy_r),
    .cfg      (cfg),
    .tgt      (tgt)
  );

  mgbp_grid_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- datapath
  // one target read issued per cycle while the list lasts
  assign sel_idx = (rd_idx < TGT_IDX_W'(TGT_MAX)) ? rd_idx : '0;
  assign issue   = (state == ST_RUN) && !tgt.err && (rd_idx < tgt.cnt);

  assign ram_raddr = (state == ST_RUN) ? tgt.entry[sel_idx].addr[ADDR_W-1:0]
                                       : ADDR_W'(faddr_r);

  // read data is stale when the previous cycle wrote the same entry
  assign base = fwd ? fwd_data : ram_rdata;

  always_comb begin
    case (pend_w)
      W_FULL:  addend = sample_r;
      W_HALF:  addend = {sample_r[31], sample_r[31:1]};
      W_QUART: addend = {{2{sample_r[31]}}, sample_r[31:2]};
      default: addend = sample_r;
    endcase
  end

  // saturating add
  assign sum_wide = {base[31], base} + {addend[31], addend};
  assign sat_now  = sum_wide[32] ^ sum_wide[31];
  assign sum_sat  = !sat_now ? sum_wide[31:0]
                  : (sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  assign ram_we    = ((state == ST_RUN) && pend) ||
                     ((state == ST_MEM) && (kind_r == K_LOAD) && !faddr_err);
  assign ram_waddr = (state == ST_RUN) ? pend_addr : ADDR_W'(faddr_r);
  assign ram_wdata = (state == ST_RUN) ? sum_sat : sample_r;

  // result fields
  always_comb begin
    res_read = 32'd0;
    if (kind_r == K_LOAD || kind_r == K_READ) begin
      res_status = faddr_err ? STAT_RANGE : STAT_OK;
      if (kind_r == K_READ && !faddr_err) begin
        res_read = res_value;
      end
    end else if (tgt.err) begin
      res_status = STAT_RANGE;
    end else begin
      res_status = sat_seen ? STAT_SAT : STAT_OK;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind_t'(kind) == K_LOAD || kind_t'(kind) == K_READ) begin
            state_next = ST_MEM;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL:   state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_RUN;
      // the last write goes out in the cycle that leaves
      ST_RUN: begin
        if (!issue) begin
          state_next = ST_DONE;
        end
      end
      ST_MEM:   state_next = (kind_r == K_READ) ? ST_RDCAP : ST_DONE;
      ST_RDCAP: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // control registers of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      pend      <= 1'b0;
      fwd       <= 1'b0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        rd_idx   <= '0;
        sat_seen <= 1'b0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      pend <= issue;
      fwd  <= issue && ram_we && (ram_raddr == ram_waddr);
      if ((state == ST_RUN) && pend && sat_now) begin
        sat_seen <= 1'b1;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(kind);
      faddr_r  <= fine_address;
      cx_r     <= coarse_x;
      cy_r     <= coarse_y;
      sample_r <= sample_value;
    end
    if (issue) begin
      pend_addr <= tgt.entry[sel_idx].addr[ADDR_W-1:0];
      pend_w    <= tgt.entry[sel_idx].w;
    end
    fwd_data <= ram_wdata;
    if (state == ST_RDCAP) begin
      res_value <= ram_rdata;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      read_value <= res_read;
      status     <= res_status;
    end
  end

  // ---------------------------------------------------------------- checks
  // grid writes happen only in the update sweep or a load
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_RUN || state == ST_MEM))
    else $error("grid write outside update or load");

  // a rejected coarse word leaves the grid untouched
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && tgt.err) |-> !ram_we)
    else $error("grid written for a rejected coarse word");

  // forwarding only follows a write in the cycle before
  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(ram_we))
    else $error("forwarded data without a preceding write");

  // result status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_OK || status == STAT_RANGE || status == STAT_SAT))
    else $error("undefined status code");

endmodule
